// File: rtl/png_header_validator_macros.svh
// Assertion macros shared by the PNG header validator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PNG_HEADER_VALIDATOR_MACROS_SVH
`define PNG_HEADER_VALIDATOR_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define PNGV_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define PNGV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pngv_pkg.sv
// Types, constants and the byte-wide CRC-32 step for the PNG header validator.
// No dependencies; imported by every module of the block.
package pngv_pkg;

   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 6;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIG    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_IHDR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CRC_ERR    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_FIELDS = 3'd5;

   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [31:0] ALL_ONES  = 32'hffffffff;
   localparam logic [31:0] IHDR_TYPE = 32'h49484452;
   localparam logic [31:0] IHDR_LEN  = 32'd13;
   localparam logic [7:0]  MAX_COLOR = 8'd6;

   // File offsets of the header layout
   localparam logic [COUNT_W-1:0] OFS_LEN     = 6'd8;
   localparam logic [COUNT_W-1:0] OFS_TYPE    = 6'd12;
   localparam logic [COUNT_W-1:0] OFS_WIDTH   = 6'd16;
   localparam logic [COUNT_W-1:0] OFS_HEIGHT  = 6'd20;
   localparam logic [COUNT_W-1:0] OFS_DEPTH   = 6'd24;
   localparam logic [COUNT_W-1:0] OFS_COLOR   = 6'd25;
   localparam logic [COUNT_W-1:0] OFS_CRC_END = 6'd28;
   localparam logic [COUNT_W-1:0] OFS_STORED  = 6'd29;
   localparam logic [COUNT_W-1:0] HDR_BYTES   = 6'd33;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [31:0]         image_width_out;
      logic [31:0]         image_height_out;
   } result_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h89;
         3'd1: b = 8'h50;
         3'd2: b = 8'h4e;
         3'd3: b = 8'h47;
         3'd4: b = 8'h0d;
         3'd5: b = 8'h0a;
         3'd6: b = 8'h1a;
         3'd7: b = 8'h0a;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Eight reflected bit steps; unrolls into one XOR tree
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: rtl/pngv_parser.sv
// Header parser: byte counter, signature check, field capture and CRC-32.
// Produces the verdict for a final word combinationally; uses pngv_pkg.
`include "png_header_validator_macros.svh"

module pngv_parser
   import pngv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result
);

   logic [COUNT_W-1:0] count_ff, count_in, count_upd;
   logic               sig_bad_ff, sig_bad_in, sig_bad_upd;
   logic [31:0]        crc_ff, crc_in, crc_upd;
   logic [31:0]        len_ff, len_in, len_upd;
   logic [31:0]        type_ff, type_in, type_upd;
   logic [31:0]        width_ff, width_in, width_upd;
   logic [31:0]        height_ff, height_in, height_upd;
   logic [7:0]         depth_ff, depth_in, depth_upd;
   logic [7:0]         color_ff, color_in, color_upd;
   logic [31:0]        stored_ff, stored_in, stored_upd;
   logic               crc_ok;

   always_comb begin
      count_upd   = count_ff;
      sig_bad_upd = sig_bad_ff;
      crc_upd     = crc_ff;
      len_upd     = len_ff;
      type_upd    = type_ff;
      width_upd   = width_ff;
      height_upd  = height_ff;
      depth_upd   = depth_ff;
      color_upd   = color_ff;
      stored_upd  = stored_ff;
      // bytes past the header leave everything alone
      if (step && (count_ff < HDR_BYTES)) begin
         priority if (count_ff < OFS_LEN) begin
            if (data_byte != sig_byte(count_ff[2:0])) sig_bad_upd = 1'b1;
         end else if (count_ff < OFS_TYPE) begin
            len_upd = {len_ff[23:0], data_byte};
         end else if (count_ff < OFS_WIDTH) begin
            type_upd = {type_ff[23:0], data_byte};
         end else if (count_ff < OFS_HEIGHT) begin
            width_upd = {width_ff[23:0], data_byte};
         end else if (count_ff < OFS_DEPTH) begin
            height_upd = {height_ff[23:0], data_byte};
         end else if (count_ff == OFS_DEPTH) begin
            depth_upd = data_byte;
         end else if (count_ff == OFS_COLOR) begin
            color_upd = data_byte;
         end else if (count_ff >= OFS_STORED) begin
            stored_upd = {stored_ff[23:0], data_byte};
         end else begin
            // filter, compression and interlace bytes: CRC only
         end
         if ((count_ff >= OFS_TYPE) && (count_ff <= OFS_CRC_END)) begin
            crc_upd = crc_byte(crc_ff, data_byte);
         end
         count_upd = count_ff + 6'd1;
      end
   end

   // A final word returns all state to reset for the next file
   always_comb begin
      if (step && last_byte) begin
         count_in   = '0;
         sig_bad_in = 1'b0;
         crc_in     = ALL_ONES;
         len_in     = '0;
         type_in    = '0;
         width_in   = '0;
         height_in  = '0;
         depth_in   = '0;
         color_in   = '0;
         stored_in  = '0;
      end else begin
         count_in   = count_upd;
         sig_bad_in = sig_bad_upd;
         crc_in     = crc_upd;
         len_in     = len_upd;
         type_in    = type_upd;
         width_in   = width_upd;
         height_in  = height_upd;
         depth_in   = depth_upd;
         color_in   = color_upd;
         stored_in  = stored_upd;
      end
   end

   // The CRC stops at offset 28, so the registered value is final once
   // all 33 bytes are in; only the stored CRC may take its last byte now.
   always_comb begin
      crc_ok = 1'b0;
      priority if (count_upd < OFS_LEN) begin
         result.status = ST_TOO_SHORT;
      end else if (sig_bad_upd) begin
         result.status = ST_BAD_SIG;
      end else if (count_upd < HDR_BYTES) begin
         result.status = ST_TOO_SHORT;
      end else if ((type_upd != IHDR_TYPE) || (len_upd != IHDR_LEN)) begin
         result.status = ST_BAD_IHDR;
      end else if (stored_upd != ~crc_ff) begin
         result.status = ST_CRC_ERR;
      end else begin
         crc_ok = 1'b1;
         if ((width_upd == '0) || (height_upd == '0) || (depth_upd == '0) ||
             (color_upd > MAX_COLOR)) begin
            result.status = ST_BAD_FIELDS;
         end else begin
            result.status = ST_OK;
         end
      end
      result.image_width_out  = crc_ok ? width_upd  : '0;
      result.image_height_out = crc_ok ? height_upd : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sig_bad_ff <= 1'b0;
         crc_ff     <= ALL_ONES;
         len_ff     <= '0;
         type_ff    <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         color_ff   <= '0;
         stored_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         sig_bad_ff <= sig_bad_in;
         crc_ff     <= crc_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         color_ff   <= color_in;
         stored_ff  <= stored_in;
      end
   end

   `PNGV_ASSERT_IMPL(a_count_sat, clock, reset, 1'b1, count_ff <= HDR_BYTES, "byte count overran")
   `PNGV_ASSERT_NEXT(a_clear_after_last, clock, reset, step && last_byte, (count_ff == '0) && (crc_ff == ALL_ONES), "state not cleared after final word")
   `PNGV_ASSERT_NEXT(a_idle_holds, clock, reset, !step, (count_ff == $past(count_ff)) && (crc_ff == $past(crc_ff)), "state moved without a word")

endmodule

// File: rtl/png_header_validator.sv
// Top level of the PNG header validator: input stage, parser, result register.
// Uses pngv_pkg, pngv_parser and the assertion macro header.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata = data_byte, tlast = last_byte
//  rsp     | out | rsp_tvalid/tready    | tdata = status, width, height
//
// One word per cycle is taken unless a waiting result holds back a final word; a verdict
// leaves through the input register, then the result register.
// Reset is synchronous and clears the stage valids and the parser state.
// A waiting result stalls only final words, and new words wait behind a stalled one.
`include "png_header_validator_macros.svh"

module png_header_validator
   import pngv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [2:0] status, [34:3] width, [66:35] height, zero pad
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;
   logic       advance;
   logic       req_accept;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, verdict;

   assign advance    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   pngv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (s1_data_ff),
      .last_byte (s1_last_ff),
      .result    (verdict)
   );

   always_comb begin
      priority if (req_accept) s1_valid_in = 1'b1;
      else if (advance)        s1_valid_in = 1'b0;
      else                     s1_valid_in = s1_valid_ff;

      priority if (advance && s1_last_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready)                rsp_valid_in = 1'b0;
      else                                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on acceptance (result: on a final word's advance), hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (advance && s1_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.image_height_out,
                        rsp_data_ff.image_width_out, rsp_data_ff.status};

   `PNGV_ASSERT_NEXT(a_rsp_from_last, clock, reset, !rsp_valid_ff && !(advance && s1_last_ff), !rsp_valid_ff, "result appeared without a final word")
   `PNGV_ASSERT_IMPL(a_dims_need_crc, clock, reset, rsp_valid_ff && ((rsp_data_ff.image_width_out != '0) || (rsp_data_ff.image_height_out != '0)), (rsp_data_ff.status == ST_OK) || (rsp_data_ff.status == ST_BAD_FIELDS), "dimensions reported without a CRC pass")
   `PNGV_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff && (s1_data_ff == $past(s1_data_ff)) && (s1_last_ff == $past(s1_last_ff)), "stalled input word lost")

endmodule
